// ----- rtl/core/lattice_node_classifier_assert.svh -----
// Assertion macros for the lattice node classifier.
// Included by the modules that carry concurrent assertions; no other dependency.
`ifndef LATTICE_NODE_CLASSIFIER_ASSERT_SVH
`define LATTICE_NODE_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
`define LNC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LNC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LNC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LNC_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/core/lnc_pkg.sv -----
// Package for the lattice node classifier: field widths, codes and
// controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package lnc_pkg;

    localparam int OP_W   = 2;
    localparam int MASK_W = 10;
    localparam int RHS_W  = 4;
    localparam int CAT_W  = 3;
    localparam int CC_W   = 4;

    localparam logic [CC_W-1:0] COLUMN_COUNT_RESET = 4'd10;

    localparam logic [OP_W-1:0] OP_DEP     = 2'd0;
    localparam logic [OP_W-1:0] OP_NON_DEP = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    localparam logic [CAT_W-1:0] CAT_NONE             = 3'd0;
    localparam logic [CAT_W-1:0] CAT_MIN_DEP          = 3'd1;
    localparam logic [CAT_W-1:0] CAT_DEP              = 3'd2;
    localparam logic [CAT_W-1:0] CAT_CAND_MIN_DEP     = 3'd3;
    localparam logic [CAT_W-1:0] CAT_MAX_NON_DEP      = 3'd4;
    localparam logic [CAT_W-1:0] CAT_NON_DEP          = 3'd5;
    localparam logic [CAT_W-1:0] CAT_CAND_MAX_NON_DEP = 3'd6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_QUERY,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic scan_last;
        logic clear_last;
    } status_t;

endpackage

// ----- rtl/core/lattice_node_classifier.sv -----
// Top level of the lattice node classifier: ports and the controller and
// datapath instances. Depends on lnc_pkg, lnc_ctrl and lnc_datapath.
`timescale 1ns / 1ps

// Keeps a category for every lattice node (column bitmask, 2^COLUMNS entries)
// and classifies nodes from their one-column-smaller subsets or one-column
// larger supersets. After reset the table is cleared entry by entry with
// in_stall high; configuration writes are taken throughout. A classify item
// makes one table read per column over the single read port, lets the last
// read land in the drain state and writes its category back in the finish
// state; a query reads its node's entry directly. The next item is taken only
// after the result is written to the output register, which out_stall can
// hold off. A finished result waits in the output register while the next
// item is accepted.
module lattice_node_classifier #(
    parameter int COLUMNS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lnc_pkg::CC_W-1:0]     column_count,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lnc_pkg::OP_W-1:0]     operation,
    input  logic [lnc_pkg::MASK_W-1:0]   node_mask,
    input  logic [lnc_pkg::RHS_W-1:0]    rhs_column,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lnc_pkg::CAT_W-1:0]    category,
    output logic                         is_candidate
);

    lnc_pkg::cmd_t    cmd;
    lnc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    lnc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lnc_datapath #(
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .column_count (column_count),
        .operation    (operation),
        .node_mask    (node_mask),
        .rhs_column   (rhs_column),
        .category     (category),
        .is_candidate (is_candidate)
    );

endmodule

// ----- rtl/core/lnc_datapath.sv -----
// Datapath of the lattice node classifier: category table, neighbor scan,
// result register. Depends on lnc_pkg; driven by lnc_ctrl commands.
`timescale 1ns / 1ps
`include "lattice_node_classifier_assert.svh"

module lnc_datapath #(
    parameter int COLUMNS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lnc_pkg::cmd_t                cmd,
    output lnc_pkg::status_t             status,
    input  logic                         cfg_we,
    input  logic [lnc_pkg::CC_W-1:0]     column_count,
    input  logic [lnc_pkg::OP_W-1:0]     operation,
    input  logic [lnc_pkg::MASK_W-1:0]   node_mask,
    input  logic [lnc_pkg::RHS_W-1:0]    rhs_column,
    output logic [lnc_pkg::CAT_W-1:0]    category,
    output logic                         is_candidate
);

    localparam int DEPTH = 1 << COLUMNS;
    localparam int IDX_W = $clog2(COLUMNS);
    localparam int EXT_W = (COLUMNS > lnc_pkg::MASK_W) ? COLUMNS : lnc_pkg::MASK_W;

    logic [lnc_pkg::CAT_W-1:0] mem [DEPTH];

    logic [lnc_pkg::CC_W-1:0]  column_count_reg;
    logic [lnc_pkg::OP_W-1:0]  op_reg;
    logic [COLUMNS-1:0]        node_reg;
    logic [lnc_pkg::RHS_W-1:0] rhs_reg;
    logic [IDX_W-1:0]          scan_idx_reg;
    logic [COLUMNS-1:0]        clr_cnt_reg;
    logic                      rd_valid_reg;
    logic [lnc_pkg::CAT_W-1:0] rd_data_reg;
    logic                      dep_hit_reg;
    logic                      non_dep_hit_reg;
    logic                      unseen_reg;
    logic [lnc_pkg::CAT_W-1:0] category_reg;
    logic                      is_candidate_reg;

    logic [COLUMNS-1:0]        use_mask;
    logic [COLUMNS-1:0]        rhs_bit;
    logic [COLUMNS-1:0]        free_cols;
    logic [EXT_W-1:0]          mask_wide;
    logic [COLUMNS-1:0]        node_in;
    logic [COLUMNS-1:0]        sel;
    logic                      relevant;
    logic [COLUMNS-1:0]        raddr;
    logic                      we;
    logic [COLUMNS-1:0]        waddr;
    logic [lnc_pkg::CAT_W-1:0] wdata;
    logic                      single;
    logic [lnc_pkg::CAT_W-1:0] cat_next;
    logic                      dep_hit_next;
    logic                      non_dep_hit_next;
    logic                      unseen_next;

    always_comb
    begin
        for (int i = 0; i < COLUMNS; i++)
        begin
            use_mask[i] = int'(column_count_reg) > i;
            rhs_bit[i]  = int'(rhs_reg) == i;
        end
    end

    assign mask_wide = EXT_W'(node_mask);
    assign node_in   = mask_wide[COLUMNS-1:0] & use_mask;
    assign free_cols = ~node_reg & use_mask & ~rhs_bit;
    assign sel       = COLUMNS'(1) << scan_idx_reg;
    assign single    = (node_reg & (node_reg - COLUMNS'(1))) == '0;

    always_comb
    begin
        if (op_reg == lnc_pkg::OP_DEP)
        begin
            relevant = node_reg[scan_idx_reg];
        end
        else
        begin
            relevant = free_cols[scan_idx_reg];
        end
    end

    always_comb
    begin
        raddr = node_reg;
        if (cmd.scan)
        begin
            raddr = (op_reg == lnc_pkg::OP_DEP) ? (node_reg & ~sel) : (node_reg | sel);
        end
    end

    always_comb
    begin
        dep_hit_next     = dep_hit_reg;
        non_dep_hit_next = non_dep_hit_reg;
        unseen_next      = unseen_reg;
        if (cmd.load)
        begin
            dep_hit_next     = 1'b0;
            non_dep_hit_next = 1'b0;
            unseen_next      = 1'b0;
        end
        else if (rd_valid_reg)
        begin
            case (rd_data_reg) inside
                lnc_pkg::CAT_NONE:
                    unseen_next = 1'b1;
                lnc_pkg::CAT_MIN_DEP, lnc_pkg::CAT_DEP, lnc_pkg::CAT_CAND_MIN_DEP:
                    dep_hit_next = 1'b1;
                lnc_pkg::CAT_MAX_NON_DEP, lnc_pkg::CAT_NON_DEP,
                lnc_pkg::CAT_CAND_MAX_NON_DEP:
                    non_dep_hit_next = 1'b1;
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (op_reg)
            lnc_pkg::OP_DEP:
            begin
                if (single)
                    cat_next = lnc_pkg::CAT_MIN_DEP;
                else if (dep_hit_reg)
                    cat_next = lnc_pkg::CAT_DEP;
                else if (unseen_reg)
                    cat_next = lnc_pkg::CAT_CAND_MIN_DEP;
                else
                    cat_next = lnc_pkg::CAT_MIN_DEP;
            end
            lnc_pkg::OP_NON_DEP:
            begin
                if (non_dep_hit_reg)
                    cat_next = lnc_pkg::CAT_NON_DEP;
                else if (unseen_reg)
                    cat_next = lnc_pkg::CAT_CAND_MAX_NON_DEP;
                else
                    cat_next = lnc_pkg::CAT_MAX_NON_DEP;
            end
            default:
                cat_next = rd_data_reg;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = node_reg;
        wdata = cat_next;
        if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = lnc_pkg::CAT_NONE;
        end
        else if (cmd.finish && (op_reg == lnc_pkg::OP_DEP || op_reg == lnc_pkg::OP_NON_DEP))
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            node_reg <= node_in;
            rhs_reg  <= rhs_column;
        end
        if (cmd.finish)
        begin
            category_reg     <= cat_next;
            is_candidate_reg <= (cat_next == lnc_pkg::CAT_CAND_MIN_DEP)
                                || (cat_next == lnc_pkg::CAT_CAND_MAX_NON_DEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= lnc_pkg::COLUMN_COUNT_RESET;
            scan_idx_reg     <= '0;
            clr_cnt_reg      <= '0;
            rd_valid_reg     <= 1'b0;
            dep_hit_reg      <= 1'b0;
            non_dep_hit_reg  <= 1'b0;
            unseen_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                column_count_reg <= column_count;
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + COLUMNS'(1);
            end
            rd_valid_reg    <= cmd.scan && relevant;
            dep_hit_reg     <= dep_hit_next;
            non_dep_hit_reg <= non_dep_hit_next;
            unseen_reg      <= unseen_next;
        end
    end

    assign status.is_query   = !(operation == lnc_pkg::OP_DEP || operation == lnc_pkg::OP_NON_DEP);
    assign status.scan_last  = scan_idx_reg == IDX_W'(COLUMNS - 1);
    assign status.clear_last = &clr_cnt_reg;

    assign category     = category_reg;
    assign is_candidate = is_candidate_reg;

    `LNC_NEVER(a_scan_idx_range, clk, rst_n, cmd.scan && (int'(scan_idx_reg) >= COLUMNS), "scan index out of range")
    `LNC_NEVER(a_write_during_scan, clk, rst_n, we && (cmd.scan || rd_valid_reg), "table written while neighbors are read")
    `LNC_ASSERT(a_clear_wraps, clk, rst_n, $past(cmd.clear) && $past(status.clear_last) |-> clr_cnt_reg == '0, "clear counter did not wrap")

endmodule

// ----- rtl/core/lnc_ctrl.sv -----
// Controller of the lattice node classifier: sequences clear, scan and
// result handoff. Depends on lnc_pkg; drives lnc_datapath commands.
`timescale 1ns / 1ps
`include "lattice_node_classifier_assert.svh"

module lnc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  lnc_pkg::status_t status,
    output lnc_pkg::cmd_t    cmd
);

    lnc_pkg::state_t state_reg;
    lnc_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lnc_pkg::S_CLEAR:
                if (status.clear_last)
                    state_next = lnc_pkg::S_IDLE;
            lnc_pkg::S_IDLE:
                if (in_valid)
                    state_next = status.is_query ? lnc_pkg::S_QUERY : lnc_pkg::S_SCAN;
            lnc_pkg::S_SCAN:
                if (status.scan_last)
                    state_next = lnc_pkg::S_DRAIN;
            lnc_pkg::S_QUERY:
                state_next = lnc_pkg::S_FINISH;
            lnc_pkg::S_DRAIN:
                state_next = lnc_pkg::S_FINISH;
            lnc_pkg::S_FINISH:
                if (out_free)
                    state_next = lnc_pkg::S_IDLE;
            default:
                state_next = lnc_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            lnc_pkg::S_CLEAR:  cmd.clear  = 1'b1;
            lnc_pkg::S_IDLE:   cmd.load   = in_valid;
            lnc_pkg::S_SCAN:   cmd.scan   = 1'b1;
            lnc_pkg::S_FINISH: cmd.finish = out_free;
            default:           cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lnc_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != lnc_pkg::S_IDLE;
    assign out_valid = out_valid_reg;

    `LNC_NEVER(a_finish_overwrite, clk, rst_n, cmd.finish && out_valid_reg && out_stall, "result overwritten before it was taken")
    `LNC_ASSERT(a_drain_after_scan, clk, rst_n, state_reg == lnc_pkg::S_DRAIN |-> $past(state_reg) == lnc_pkg::S_SCAN, "drain without scan")
    `LNC_ASSERT(a_finish_entry, clk, rst_n, $rose(state_reg == lnc_pkg::S_FINISH) |-> $past(state_reg) == lnc_pkg::S_DRAIN || $past(state_reg) == lnc_pkg::S_QUERY, "finish entered out of order")
    `LNC_ASSERT(a_result_after_finish, clk, rst_n, $rose(out_valid_reg) |-> $past(cmd.finish), "result shown without finish")

endmodule
